FILE: rtl/dpf_pkg.sv
// Shared types and constants for the duplicate packet filter.
package dpf_pkg;

   // Default number of sender history entries.
   localparam int HISTORY_DEPTH_DEFAULT = 10;

   // Payload field widths.
   localparam int ADDR_W = 16;
   localparam int SEQ_W  = 8;

   // One history table entry as stored in the memory.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SEQ_W-1:0]  seq;
   } entry_type;

   // Memory port strobes from the scan controller.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   // Flags of one result transfer.
   typedef struct packed {
      logic is_duplicate;
      logic new_sender;
      logic evicted_entry;
   } result_type;

endpackage

FILE: rtl/dpf_channels.sv
// Valid/ready channel interfaces for packet requests and filter responses.
interface dpf_req_if;
   import dpf_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] sender_addr;
   logic [SEQ_W-1:0]  seq_num;

   modport source (output valid, output sender_addr, output seq_num, input ready);
   modport sink (input valid, input sender_addr, input seq_num, output ready);
endinterface

interface dpf_rsp_if;
   logic valid;
   logic ready;
   logic is_duplicate;
   logic new_sender;
   logic evicted_entry;

   modport source (output valid, output is_duplicate, output new_sender,
                   output evicted_entry, input ready);
   modport sink (input valid, input is_duplicate, input new_sender,
                 input evicted_entry, output ready);
endinterface

FILE: rtl/dpf_hist_mem.sv
// Sender history memory: one write port and one read port with registered read data.
module dpf_hist_mem #(
   parameter int HISTORY_DEPTH = dpf_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int IDX_W         = 4
) (
   input  logic                  clock,
   input  dpf_pkg::mem_ctl_type  mem_ctl,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [IDX_W-1:0]      wr_idx,
   input  dpf_pkg::entry_type    wr_data,
   output dpf_pkg::entry_type    rd_data
);
   import dpf_pkg::*;

   entry_type hist_mem [HISTORY_DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         hist_mem[wr_idx] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= hist_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dpf_scan_ctrl.sv
// Scan controller: walks the history memory, decides the outcome and updates the table.
module dpf_scan_ctrl #(
   parameter int HISTORY_DEPTH = dpf_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int IDX_W         = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   dpf_req_if.sink               req_ch,
   dpf_rsp_if.source             rsp_ch,
   output dpf_pkg::mem_ctl_type  mem_ctl,
   output logic [IDX_W-1:0]      rd_idx,
   output logic [IDX_W-1:0]      wr_idx,
   output dpf_pkg::entry_type    wr_data,
   input  dpf_pkg::entry_type    rd_data
);
   import dpf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [IDX_W-1:0]        issue_idx_ff, issue_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   result_type              res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_res_ff, rsp_res_in;
   logic                    hit;

   // An entry matches when it is valid and holds the sender's address.
   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_data.addr == addr_ff);

   // Every table write stores the current packet's address and number.
   assign wr_data = '{addr: addr_ff, seq: seq_ff};

   // Next-state and datapath decisions.
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      seq_in       = seq_ff;
      issue_idx_in = issue_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      valid_in     = valid_ff;
      ptr_in       = ptr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_res_in   = rsp_res_ff;
      mem_ctl      = '0;
      rd_idx       = issue_idx_ff;
      wr_idx       = cmp_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               addr_in      = req_ch.sender_addr;
               seq_in       = req_ch.seq_num;
               issue_idx_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               // Known sender: flag a repeat, otherwise refresh its number.
               res_in = '{is_duplicate: (rd_data.seq == seq_ff),
                          new_sender: 1'b0, evicted_entry: 1'b0};
               mem_ctl.wr_en = (rd_data.seq != seq_ff);
               state_in      = ST_RESULT;
            end else if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
               // Unknown sender: insert at the oldest slot and advance.
               mem_ctl.wr_en    = 1'b1;
               wr_idx           = ptr_ff;
               res_in           = '{is_duplicate: 1'b0, new_sender: 1'b1,
                                    evicted_entry: valid_ff[ptr_ff]};
               valid_in[ptr_ff] = 1'b1;
               ptr_in           = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               state_in         = ST_RESULT;
            end else begin
               // Issue the next read; its data is compared next cycle.
               mem_ctl.rd_en = 1'b1;
               cmp_vld_in    = 1'b1;
               cmp_idx_in    = issue_idx_ff;
               if (issue_idx_ff != LAST_IDX) begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      seq_ff       <= seq_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      res_ff       <= res_in;
      rsp_res_ff   <= rsp_res_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.is_duplicate   = rsp_res_ff.is_duplicate;
   assign rsp_ch.new_sender     = rsp_res_ff.new_sender;
   assign rsp_ch.evicted_entry  = rsp_res_ff.evicted_entry;

endmodule

FILE: rtl/duplicate_packet_filter_unit.sv
// Top level of the duplicate packet filter: history memory plus scan controller.
// Each received packet's sender address is looked up in a history of HISTORY_DEPTH
// senders held in a single-port-read, single-port-write memory, read one entry per
// cycle. A packet is taken in, then the entries are read in order from entry 0 and
// each registered read is compared, the scan stopping at the first matching entry
// or after the last one; the result is then handed over. Unknown senders replace
// the oldest inserted entry. A finished result waits in an output register, so the
// next packet is taken while the previous response is still pending. Entry valid
// bits are cleared at reset, so no clearing pass is needed.
module duplicate_packet_filter_unit #(
   parameter int HISTORY_DEPTH = dpf_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dpf_req_if.sink    req_ch,
   dpf_rsp_if.source  rsp_ch
);
   import dpf_pkg::*;

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   mem_ctl_type       mem_ctl;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_data;
   entry_type         rd_data;

   // History memory.
   dpf_hist_mem #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .IDX_W         (IDX_W)
   ) u_hist_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_idx  (rd_idx),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Lookup and update sequencer.
   dpf_scan_ctrl #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .IDX_W         (IDX_W)
   ) u_scan_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mem_ctl (mem_ctl),
      .rd_idx  (rd_idx),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // A request transfer starts a scan, so no second request is taken right after.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while a scan was starting");

   // Reads and writes never share a cycle; the table changes only at scan end.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd_en && mem_ctl.wr_en))
      else $error("memory read and write in the same cycle");

   // A table write is followed by no further memory reads in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |=> !mem_ctl.rd_en)
      else $error("memory read right after the closing write");

   // Outcome flags are consistent: eviction only on insertion, never both kinds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (!(rsp_ch.is_duplicate && rsp_ch.new_sender)
                        && (!rsp_ch.evicted_entry || rsp_ch.new_sender)))
      else $error("inconsistent response flags");

endmodule

FILE: test/duplicate_packet_filter_unit_tb.sv
// Self-checking testbench for the duplicate packet filter with its own history predictor.
module duplicate_packet_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpf_pkg::*;

   localparam int DEPTH        = 10;
   localparam int RANDOM_ITEMS = 560;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AT      = 150;
   localparam int BURST_FIRST  = 300;
   localparam int BURST_LAST   = 380;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SEQ_W-1:0]  seq;
   } packet_type;

   logic clock;
   logic reset;

   dpf_req_if req_ch ();
   dpf_rsp_if rsp_ch ();

   duplicate_packet_filter_unit #(
      .HISTORY_DEPTH(DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Packets waiting to be sent and flags waiting to be seen.
   packet_type packet_queue[$];
   result_type expected_flags[$];

   // Predicted contents of the sender history table.
   logic [ADDR_W-1:0] hist_addr [DEPTH];
   logic [SEQ_W-1:0]  hist_seq [DEPTH];
   logic              hist_valid [DEPTH];
   int                hist_next;

   int total_packets;
   int sent_count;
   int rsp_count;
   int fail_count;
   int cycle_count;
   int gap_left;
   int stall_left;

   // Look a sender up in the predicted table, update it and return the flags.
   function automatic result_type lookup_sender(input logic [ADDR_W-1:0] addr,
                                                input logic [SEQ_W-1:0] seq);
      result_type flags;
      flags = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hist_valid[i] && hist_addr[i] == addr) begin
            if (hist_seq[i] == seq) begin
               flags.is_duplicate = 1'b1;
            end else begin
               hist_seq[i] = seq;
            end
            return flags;
         end
      end
      // Unknown sender goes into the oldest inserted slot.
      flags.new_sender    = 1'b1;
      flags.evicted_entry = hist_valid[hist_next];
      hist_addr[hist_next]  = addr;
      hist_seq[hist_next]   = seq;
      hist_valid[hist_next] = 1'b1;
      hist_next = (hist_next + 1 >= DEPTH) ? 0 : hist_next + 1;
      return flags;
   endfunction

   // Wait drawn for one item; a window of items runs with no idling at all.
   function automatic int draw_wait(input int index);
      if (index >= BURST_FIRST && index <= BURST_LAST) begin
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic add_packet(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
      packet_type pkt;
      pkt.addr = addr;
      pkt.seq  = seq;
      packet_queue.push_back(pkt);
      total_packets++;
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Request driver: presents queued packets and predicts each accepted transfer.
   always @(posedge clock) begin : drive_requests
      packet_type pkt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_flags.push_back(lookup_sender(req_ch.sender_addr, req_ch.seq_num));
            sent_count <= sent_count + 1;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // Hold the offered packet until it is taken.
         end else if (gap_left != 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (packet_queue.size() != 0) begin
            pkt = packet_queue.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.sender_addr <= pkt.addr;
            req_ch.seq_num     <= pkt.seq;
            gap_left           <= draw_wait(sent_count + 1);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each transfer and throttles ready.
   always @(posedge clock) begin : check_responses
      result_type want;
      int         next_stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         next_stall = stall_left;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_flags.size() == 0) begin
               $error("response transfer with no packet outstanding");
               fail_count++;
            end else begin
               want = expected_flags.pop_front();
               if (rsp_ch.is_duplicate !== want.is_duplicate) begin
                  $error("is_duplicate: expected %0b, actual %0b",
                         want.is_duplicate, rsp_ch.is_duplicate);
                  fail_count++;
               end
               if (rsp_ch.new_sender !== want.new_sender) begin
                  $error("new_sender: expected %0b, actual %0b",
                         want.new_sender, rsp_ch.new_sender);
                  fail_count++;
               end
               if (rsp_ch.evicted_entry !== want.evicted_entry) begin
                  $error("evicted_entry: expected %0b, actual %0b",
                         want.evicted_entry, rsp_ch.evicted_entry);
                  fail_count++;
               end
            end
            rsp_count <= rsp_count + 1;
            // One long hold-off lets the block fill up and stall its input.
            next_stall = (rsp_count + 1 == HOLD_AT) ? LONG_HOLD : draw_wait(rsp_count + 1);
         end
         if (next_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= next_stall - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= 0;
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      logic [ADDR_W-1:0] pool [16];
      logic [ADDR_W-1:0] addr;
      logic [SEQ_W-1:0]  seq;
      int                pick;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sender_addr = '0;
      req_ch.seq_num     = '0;
      rsp_ch.ready       = 1'b0;
      total_packets      = 0;
      sent_count         = 0;
      rsp_count          = 0;
      fail_count         = 0;
      cycle_count        = 0;
      hist_next          = 0;
      for (int i = 0; i < DEPTH; i++) begin
         hist_valid[i] = 1'b0;
         hist_addr[i]  = '0;
         hist_seq[i]   = '0;
      end

      // Directed part: extremes, duplicate, sequence update, fill and FIFO eviction.
      add_packet(16'h0000, 8'h00);
      add_packet(16'h0000, 8'h00);
      add_packet(16'h0000, 8'hFF);
      add_packet(16'h0000, 8'hFF);
      add_packet(16'hFFFF, 8'hFF);
      add_packet(16'hFFFF, 8'h00);
      for (int i = 0; i < DEPTH - 2; i++) begin
         add_packet(16'h0001 << (2 * i), 8'(i + 1));
      end
      add_packet(16'h1234, 8'h5A);
      add_packet(16'h0000, 8'h00);
      add_packet(16'hFFFF, 8'h00);
      add_packet(16'h0010, 8'h07);
      add_packet(16'h0010, 8'h07);
      add_packet(16'hAAAA, 8'hAA);
      add_packet(16'h5555, 8'h55);
      add_packet(16'h1234, 8'h5A);
      add_packet(16'h0001, 8'h01);

      // Random part: a pool a little larger than the table gives hits and evictions.
      for (int i = 0; i < 16; i++) begin
         pool[i] = 16'($urandom);
      end
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            addr = 16'($urandom);
         end else if (pick <= 6) begin
            addr = pool[$urandom_range(0, 13)];
         end else begin
            addr = pool[$urandom_range(0, 5)];
         end
         seq = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         add_packet(addr, seq);
         // Occasionally repeat a packet to hit the duplicate path directly.
         if ($urandom_range(0, 7) == 0) begin
            add_packet(addr, seq);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_packets || expected_flags.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
